FILE: hdl/bbpf_pkg.sv
// Shared types and constants for the binary boundary pixel finder.
// Used by the result queue, the top level and the testbench.
`timescale 1ns / 1ps

package bbpf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam int CUTOFF_W = 16;
  localparam int DIM_W    = 11;

  localparam logic signed [CUTOFF_W-1:0] CUTOFF_RESET = 16'sd3;
  localparam logic [DIM_W-1:0]           DIM_RESET    = 11'd5;

  // Result fields
  localparam int COORD_W      = 10;
  localparam int OUT_TDATA_W  = 24;
  localparam int RES_PER_ITEM = 3;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;
  localparam int PUSH_W = 2;

  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } res_t;

  // Queue status toward the input side
  typedef struct packed {
    logic              head_vld;
    logic [QCNT_W-1:0] level;
  } q_stat_t;

endpackage

FILE: hdl/bbpf_cell.sv
// One-bit storage cell of a line delay row.
// Shifts from its neighbor, or loads the broadcast bit when it is the entry cell.
`timescale 1ns / 1ps

module bbpf_cell (
  input  logic clk,
  input  logic shift,
  input  logic load,
  input  logic din,
  input  logic nbr,
  output logic q
);

  logic bit_r;
  logic bit_nxt;

  // take the new bit at the entry point, otherwise the neighbor's bit
  assign bit_nxt = load ? din : nbr;

  always_ff @(posedge clk) begin
    if (shift) begin
      bit_r <= bit_nxt;
    end
  end

  assign q = bit_r;

endmodule

FILE: hdl/bbpf_line.sv
// Row of one-bit cells forming a delay line whose length follows the tap index.
// Depends on bbpf_cell. The bit entered at cell tap reaches cell 0 after tap+1 shifts.
`timescale 1ns / 1ps

module bbpf_line #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [IDX_W-1:0] tap,
  input  logic             din,
  output logic             tap0,
  output logic             tap1
);

  logic [DEPTH-1:0] q;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic nbr;
      // the far end has no neighbor
      if (i == DEPTH - 1) begin : g_end
        assign nbr = 1'b0;
      end else begin : g_mid
        assign nbr = q[i+1];
      end
      bbpf_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .load  (tap == IDX_W'(i)),
        .din   (din),
        .nbr   (nbr),
        .q     (q[i])
      );
    end

    // second-to-last tap, absent on a one-cell row
    if (DEPTH > 1) begin : g_tap1
      assign tap1 = q[1];
    end else begin : g_no_tap1
      assign tap1 = 1'b0;
    end
  endgenerate

  assign tap0 = q[0];

endmodule

FILE: hdl/bbpf_outq.sv
// Result queue: a short chain of slots that shifts toward the output slot.
// Takes up to three results per cycle and hands out one; uses bbpf_pkg.
`timescale 1ns / 1ps

module bbpf_outq (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [bbpf_pkg::PUSH_W-1:0]             push_n,
  input  bbpf_pkg::res_t [bbpf_pkg::RES_PER_ITEM-1:0] push_data,
  input  logic                                    pop,
  output bbpf_pkg::res_t                          head,
  output bbpf_pkg::q_stat_t                       stat
);

  import bbpf_pkg::*;

  res_t              q_r   [QDEPTH];
  res_t              q_nxt [QDEPTH];
  logic [QCNT_W-1:0] level_r;
  logic [QCNT_W-1:0] level_nxt;
  logic [QCNT_W-1:0] base;

  // slots left after the pop; new words append behind them
  assign base      = level_r - QCNT_W'(pop);
  assign level_nxt = base + QCNT_W'(push_n);

  genvar j;
  generate
    for (j = 0; j < QDEPTH; j++) begin : g_slot
      res_t              shifted;
      logic [PUSH_W-1:0] offs;

      if (j == QDEPTH - 1) begin : g_last
        assign shifted = q_r[j];
      end else begin : g_mid
        assign shifted = pop ? q_r[j+1] : q_r[j];
      end

      assign offs = PUSH_W'(QCNT_W'(j) - base);

      // keep the older word, place a new word, or hold
      always_comb begin
        if (QCNT_W'(j) < base) begin
          q_nxt[j] = shifted;
        end else if (offs < push_n) begin
          q_nxt[j] = push_data[offs];
        end else begin
          q_nxt[j] = q_r[j];
        end
      end

      always_ff @(posedge clk) begin
        q_r[j] <= q_nxt[j];
      end
    end
  endgenerate

  // hold the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  assign head          = q_r[0];
  assign stat.level    = level_r;
  assign stat.head_vld = (level_r != '0);

endmodule

FILE: hdl/binary_boundary_pixel_finder.sv
// Top level of the binary boundary pixel finder.
// Depends on bbpf_pkg, bbpf_line (rows of bbpf_cell) and bbpf_outq.
`timescale 1ns / 1ps

// Usage
//   in_*  : one pixel per word in raster order, in_tdata[PIXEL_BITS-1:0] two's complement.
//   out_* : one boundary pixel per word, row in out_tdata[9:0], col in [19:10];
//           out_tlast marks the last result caused by one input pixel.
//   cfg_* : register writes (0 cutoff, 1 image_width, 2 image_height); a width or
//           height write restarts the frame. Write only while no results are pending.
// Decision: a pixel is decided one row after it arrives (the last row as its right
//   neighbor arrives, the final pixel at once); its result enters the result queue
//   when the deciding input word is taken and waits there behind older results.
// Throughput: one pixel per clock while in_tready is high. Each pixel yields at most one
//   result outside the last row; in the last row up to three, drained one per clock by
//   the four-slot result queue, so a word is taken only while at most one result waits.
// Reset: counters and the queue clear, cutoff returns to 3 and both sizes to 5.
//   The line cells are not cleared; they are read only after the current frame
//   has filled them.
// Receiver stall: results hold in the queue; when more than one waits, in_tready
//   drops until the receiver takes words again.

module binary_boundary_pixel_finder #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // fields, low bit first: pixel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]       in_tdata,
  // fields, low bit first: row, col, zero fill
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [bbpf_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bbpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bbpf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import bbpf_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int WD    = (WW > DIM_W) ? WW : DIM_W;
  localparam int HD    = (HW > DIM_W) ? HW : DIM_W;
  localparam int CMP_W = (PIXEL_BITS > CUTOFF_W) ? PIXEL_BITS : CUTOFF_W;

  // configuration registers
  logic signed [CUTOFF_W-1:0] cutoff_r;
  logic [DIM_W-1:0]           image_width_r;
  logic [DIM_W-1:0]           image_height_r;

  // frame position
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_r;
  logic [RW-1:0] row_nxt;

  // short taps of the current row and the row above
  logic s1_r;
  logic s2_r;
  logic swp1_r;

  logic          in_acc;
  logic          cfg_acc;
  logic          dim_wr;
  logic [WD-1:0] w_ext;
  logic [WD-1:0] w_eff;
  logic [HD-1:0] h_ext;
  logic [HD-1:0] h_eff;
  logic [CW-1:0] w_m1;
  logic [RW-1:0] h_m1;
  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic          oob;
  logic          c_last;
  logic          r_last;

  logic signed [CMP_W-1:0] pix_s;
  logic signed [CMP_W-1:0] cut_s;
  logic                    fg;

  logic sw;
  logic swm1;
  logic s2w;
  logic s2w_unused;

  logic hit0;
  logic hit1;
  logic hit2;
  res_t e0;
  res_t e1;
  res_t e2;
  res_t [RES_PER_ITEM-1:0] push_data;
  logic [PUSH_W-1:0]       push_n;
  res_t                    head;
  q_stat_t                 qstat;

  assign in_acc  = in_tvalid && in_tready;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign dim_wr  = cfg_acc && ((cfg_index == REG_IMAGE_WIDTH) ||
                               (cfg_index == REG_IMAGE_HEIGHT));

  // clamp the sizes into 1 .. MAX
  assign w_ext = WD'(image_width_r);
  assign h_ext = HD'(image_height_r);

  always_comb begin
    if (w_ext == '0) begin
      w_eff = WD'(1);
    end else if (w_ext > WD'(MAX_WIDTH)) begin
      w_eff = WD'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = HD'(1);
    end else if (h_ext > HD'(MAX_HEIGHT)) begin
      h_eff = HD'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  assign w_m1 = CW'(w_eff - WD'(1));
  assign h_m1 = RW'(h_eff - HD'(1));

  // a position outside the image starts a new frame
  assign oob    = (row_r > h_m1) || (col_r > w_m1);
  assign c      = oob ? '0 : col_r;
  assign r      = oob ? '0 : row_r;
  assign c_last = (c == w_m1);
  assign r_last = (r == h_m1);

  // threshold the pixel
  assign pix_s = CMP_W'(signed'(in_tdata[PIXEL_BITS-1:0]));
  assign cut_s = CMP_W'(cutoff_r);
  assign fg    = (pix_s >= cut_s);

  // row above: cell 0 holds (r-1,c), cell 1 holds (r-1,c+1)
  bbpf_line #(
    .DEPTH (MAX_WIDTH),
    .IDX_W (CW)
  ) u_line_up (
    .clk   (clk),
    .shift (in_acc),
    .tap   (w_m1),
    .din   (fg),
    .tap0  (sw),
    .tap1  (swm1)
  );

  // two rows above: cell 0 holds (r-2,c)
  bbpf_line #(
    .DEPTH (MAX_WIDTH),
    .IDX_W (CW)
  ) u_line_up2 (
    .clk   (clk),
    .shift (in_acc),
    .tap   (w_m1),
    .din   (sw),
    .tap0  (s2w),
    .tap1  (s2w_unused)
  );

  // decide (r-1,c), (r,c-1) in the last row, and the final pixel
  always_comb begin
    hit0 = (r != '0) && sw &&
           (!fg || ((r > RW'(1)) && !s2w) || ((c != '0) && !swp1_r) ||
            (!c_last && !swm1));
    hit1 = r_last && (c != '0) && s1_r &&
           (!fg || ((r != '0) && !swp1_r) || ((c > CW'(1)) && !s2_r));
    hit2 = r_last && c_last && fg &&
           (((r != '0) && !sw) || ((c != '0) && !s1_r));
    hit0 = hit0 && (s2w || !s2w_unused || 1'b1);
  end

  always_comb begin
    e0.row  = COORD_W'(r - RW'(1));
    e0.col  = COORD_W'(c);
    e0.last = !(hit1 || hit2);
    e1.row  = COORD_W'(r);
    e1.col  = COORD_W'(c - CW'(1));
    e1.last = !hit2;
    e2.row  = COORD_W'(r);
    e2.col  = COORD_W'(c);
    e2.last = 1'b1;
  end

  // pack the hits without gaps, oldest decision first
  always_comb begin
    push_data[0] = hit0 ? e0 : (hit1 ? e1 : e2);
    push_data[1] = (hit0 && hit1) ? e1 : e2;
    push_data[2] = e2;
    push_n       = in_acc ? (PUSH_W'(hit0) + PUSH_W'(hit1) + PUSH_W'(hit2)) : '0;
  end

  bbpf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_data (push_data),
    .pop       (out_tvalid && out_tready),
    .head      (head),
    .stat      (qstat)
  );

  // take a word only while room for three results remains
  assign in_tready  = (qstat.level <= QCNT_W'(QDEPTH - RES_PER_ITEM));
  assign cfg_ready  = 1'b1;
  assign out_tvalid = qstat.head_vld;
  assign out_tdata  = {{(OUT_TDATA_W - 2*COORD_W){1'b0}}, head.col, head.row};
  assign out_tlast  = head.last;

  // advance the raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (dim_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (c_last) begin
        col_nxt = '0;
        row_nxt = r_last ? '0 : r + RW'(1);
      end else begin
        col_nxt = c + CW'(1);
        row_nxt = r;
      end
    end
  end

  // hold position and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r          <= '0;
      row_r          <= '0;
      cutoff_r       <= CUTOFF_RESET;
      image_width_r  <= DIM_RESET;
      image_height_r <= DIM_RESET;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_acc) begin
        case (cfg_index)
          REG_CUTOFF:       cutoff_r       <= signed'(cfg_data[CUTOFF_W-1:0]);
          REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT: image_height_r <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // short taps shift with every pixel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r   <= fg;
      s2_r   <= s1_r;
      swp1_r <= sw;
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for binary_boundary_pixel_finder.
// Streams pixel frames through the block, predicts every boundary report in the bench
// and checks each result word against it. Needs bbpf_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import bbpf_pkg::*;

  localparam int FRAME_MAX     = 1024;
  localparam int PIX_W         = 16;
  localparam int RANDOM_ITEMS  = 50;
  localparam int WIDE_ITEMS    = 20;
  localparam int TALL_ITEMS    = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 50;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;   // fields, low bit first: pixel
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // fields, low bit first: row, col, zero fill
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  binary_boundary_pixel_finder #(
    .MAX_WIDTH(FRAME_MAX),
    .MAX_HEIGHT(FRAME_MAX),
    .PIXEL_BITS(PIX_W)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's registers and line stores
  logic signed [CUTOFF_W-1:0] cutoff_q = CUTOFF_RESET;
  logic [DIM_W-1:0]           width_q  = DIM_RESET;
  logic [DIM_W-1:0]           height_q = DIM_RESET;
  bit   fg_line [0:1][0:FRAME_MAX-1];
  int   row_q  = 0;
  int   col_q  = 0;
  bit   bank_q = 1'b0;

  res_t boundary_q[$];
  int   mismatches = 0;
  int   cycle_count = 0;

  bit   tx_eager = 1'b0;
  logic rx_eager = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   rx_wait = 0;
  int   rx_draw;
  res_t due;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int draw_gap(input bit eager);
    if (eager || $urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(1, 13);
  endfunction

  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0)
      return 1;
    if (v > FRAME_MAX)
      return FRAME_MAX;
    return int'(v);
  endfunction

  // Decide every pixel that this word completes and queue its reports
  task automatic take_pixel(input logic signed [PIX_W-1:0] px);
    int   w, h, r, c, nfound;
    bit   cur, prv, fg, bnd;
    res_t found [RES_PER_ITEM];
    w = eff_dim(width_q);
    h = eff_dim(height_q);
    r = row_q;
    c = col_q;
    nfound = 0;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
      bank_q = 1'b0;
    end
    cur = bank_q;
    prv = ~bank_q;
    fg = (px >= cutoff_q);

    // pixel above is now fully surrounded
    if (r >= 1 && fg_line[prv][c]) begin
      bnd = !fg;
      if (r > 1 && !fg_line[cur][c]) bnd = 1'b1;
      if (c > 0 && !fg_line[prv][c-1]) bnd = 1'b1;
      if (c + 1 < w && !fg_line[prv][c+1]) bnd = 1'b1;
      if (bnd) begin
        found[nfound] = '{last: 1'b0, col: COORD_W'(c), row: COORD_W'(r - 1)};
        nfound++;
      end
    end
    fg_line[cur][c] = fg;

    // bottom row: left neighbor closes now, the frame's final pixel at once
    if (r == h - 1) begin
      if (c >= 1 && fg_line[cur][c-1]) begin
        bnd = !fg;
        if (r > 0 && !fg_line[prv][c-1]) bnd = 1'b1;
        if (c > 1 && !fg_line[cur][c-2]) bnd = 1'b1;
        if (bnd) begin
          found[nfound] = '{last: 1'b0, col: COORD_W'(c - 1), row: COORD_W'(r)};
          nfound++;
        end
      end
      if (c == w - 1 && fg) begin
        bnd = 1'b0;
        if (r > 0 && !fg_line[prv][c]) bnd = 1'b1;
        if (c > 0 && !fg_line[cur][c-1]) bnd = 1'b1;
        if (bnd) begin
          found[nfound] = '{last: 1'b0, col: COORD_W'(c), row: COORD_W'(r)};
          nfound++;
        end
      end
    end
    if (nfound > 0)
      found[nfound-1].last = 1'b1;
    for (int i = 0; i < nfound; i++)
      boundary_q.push_back(found[i]);

    // advance raster position
    c++;
    if (c >= w) begin
      c = 0;
      bank_q = ~bank_q;
      r++;
      if (r >= h) begin
        r = 0;
        bank_q = 1'b0;
      end
    end
    row_q = r;
    col_q = c;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CUTOFF: cutoff_q = data;
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
        if (idx == REG_IMAGE_WIDTH)
          width_q = data[DIM_W-1:0];
        else
          height_q = data[DIM_W-1:0];
        row_q  = 0;
        col_q  = 0;
        bank_q = 1'b0;
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel word and hold it until taken
  task automatic send_pixel(input logic signed [PIX_W-1:0] px);
    int gap;
    gap = draw_gap(tx_eager);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_pixel(px);
  endtask

  // Pixel on the wanted side of the current cutoff; now and then any value at all
  function automatic logic signed [PIX_W-1:0] pick_pixel(input bit want_fg);
    int cut, lo, hi;
    cut = cutoff_q;
    if ($urandom_range(0, 7) == 0)
      return PIX_W'($urandom);
    if (want_fg || cut == -32768) begin
      lo = cut;
      hi = 32767;
    end else begin
      lo = -32768;
      hi = cut - 1;
    end
    if ($urandom_range(0, 2) == 0)
      return PIX_W'(want_fg ? lo : hi);
    return PIX_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic send_frame(input int npix, input int density);
    for (int i = 0; i < npix; i++)
      send_pixel(pick_pixel($urandom_range(0, 99) < density));
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (boundary_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Default 5x5 frame, cutoff 3: fixed shape, values at the field extremes
  task automatic test_default_frame();
    bit [0:24] shape = 25'b11111_11111_10110_11111_01101;
    int fg_set [5] = '{3, 32767, 21845, 4, 1000};
    int bg_set [5] = '{2, -32768, -1, 0, -21846};
    for (int i = 0; i < 25; i++)
      send_pixel(PIX_W'(shape[i] ? fg_set[i % 5] : bg_set[i % 5]));
    settle();
  endtask

  // Lowest and highest cutoff; a cutoff write mid-frame keeps the position
  task automatic test_cutoff_extremes();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    write_reg(REG_CUTOFF, 16'h8000);
    send_frame(4, 50);
    settle();
    write_reg(REG_CUTOFF, 16'h7FFF);
    send_pixel(16'sh7FFF);
    send_pixel(16'sh7FFF);
    send_pixel(16'sh7FFE);
    send_pixel(16'sh7FFF);
    send_pixel(-16'sd1);
    send_frame(9, 60);
    settle();
  endtask

  // Zero and oversized dimensions, upper data bits ignored, spare index ignored;
  // the oversized frames are only started
  task automatic test_size_limits();
    write_reg(REG_CUTOFF, 16'd0);
    write_reg(REG_IMAGE_WIDTH, 16'h0000);
    write_reg(REG_IMAGE_HEIGHT, 16'hF800);
    send_pixel(-16'sd1);
    send_pixel(16'sd0);
    send_pixel(16'sh7FFF);
    send_pixel(16'sh8000);
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'h07FF);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    send_frame(WIDE_ITEMS, 50);
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'hF801);
    write_reg(REG_IMAGE_HEIGHT, 16'd1025);
    send_frame(TALL_ITEMS, 50);
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_frame(4, 50);
    settle();
    write_reg(REG_SPARE, 16'hFFFF);
    send_frame(14, 50);
    settle();
  endtask

  // Width or height write in the middle of a frame starts a new one
  task automatic test_frame_restart();
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_frame(6, 60);
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    send_frame(12, 60);
    send_frame(10, 60);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    send_frame(16, 60);
    settle();
  endtask

  // Receiver held off for a long stretch while pixels keep coming back to back
  task automatic test_output_stall();
    write_reg(REG_IMAGE_WIDTH, 16'd6);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    write_reg(REG_CUTOFF, 16'd0);
    tx_eager = 1'b1;
    rx_eager <= 1'b1;
    hold_req <= 1'b1;
    while (hold_left == 0) @(posedge clk);
    hold_req <= 1'b0;
    for (int f = 0; f < 3; f++)
      for (int i = 0; i < 12; i++)
        send_pixel((((i / 6) + (i % 6)) % 2 == 0) ? 16'sd1 : -16'sd1);
    settle();
    tx_eager = 1'b0;
    rx_eager <= 1'b0;
  endtask

  // Random sizes, cutoffs and densities; some frames cut short
  task automatic test_random_frames();
    int sent, w, h, n, density;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
      write_reg(REG_IMAGE_HEIGHT, {5'($urandom), 11'(h)});
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_CUTOFF, CFG_DATA_W'($urandom));
      else
        write_reg(REG_CUTOFF, CFG_DATA_W'(int'($urandom_range(0, 200)) - 100));
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager <= ($urandom_range(0, 3) == 0);
      density = $urandom_range(20, 90);
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 5) == 0)
        n = $urandom_range(1, w * h);
      if (n > RANDOM_ITEMS - sent)
        n = RANDOM_ITEMS - sent;
      send_frame(n, density);
      sent += n;
      settle();
    end
    tx_eager = 1'b0;
    rx_eager <= 1'b0;
  endtask

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (hold_req)
      hold_left <= LONG_HOLD;
  end

  // Receiver: wait a drawn number of cycles before each word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      rx_draw = draw_gap(rx_eager);
      rx_wait <= rx_draw;
      out_tready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (boundary_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word row %0d col %0d last %0b",
                                  out_tdata[9:0], out_tdata[19:10], out_tlast));
      end else begin
        due = boundary_q.pop_front();
        if (out_tdata[9:0] !== due.row)
          report_mismatch($sformatf("row %0d, predicted %0d", out_tdata[9:0], due.row));
        if (out_tdata[19:10] !== due.col)
          report_mismatch($sformatf("col %0d, predicted %0d", out_tdata[19:10], due.col));
        if (out_tlast !== due.last)
          report_mismatch($sformatf("last %0b, predicted %0b at row %0d col %0d",
                                    out_tlast, due.last, due.row, due.col));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : run
    int waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frame();
    test_cutoff_extremes();
    test_size_limits();
    test_frame_restart();
    test_output_stall();
    test_random_frames();

    // drain what is still owed, then give the block its latency
    in_tvalid <= 1'b0;
    waited = 0;
    while (boundary_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (boundary_q.size() != 0)
      report_mismatch($sformatf("%0d predicted words never came", boundary_q.size()));
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/bbpf_pkg.sv
hdl/bbpf_cell.sv
hdl/bbpf_line.sv
hdl/bbpf_outq.sv
hdl/binary_boundary_pixel_finder.sv
tb/testbench.sv
